### hw/rtl/oxy_pkg.sv
// Package for the oxygen sensor smoothing and calibration block.
// Holds field widths, command and register codes, arithmetic constants
// and the sequencer state type. No dependencies.
package oxy_pkg;

   localparam int WFB_DEFAULT = 10;
   localparam int SB_DEFAULT  = 16;

   localparam int CMD_W    = 2;
   localparam int MV_W     = 16;
   localparam int WEIGHT_W = 11;
   localparam int GAIN_W   = 16;
   localparam int OXY_W    = 7;
   localparam int EFF_W    = 8;
   localparam int CSR_A_W  = 2;
   localparam int CSR_D_W  = 16;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CAP_LO = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CAP_HI = 2'd2;

   localparam logic [CSR_A_W-1:0] CSR_WEIGHT = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_GAIN   = 2'd1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 11'd307;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd8624;
   localparam logic [MV_W-1:0]     HI_OFF_RESET = 16'd70;
   localparam logic [MV_W-1:0]     LO_OFF_RESET = 16'd13;

   // oxygen = (208*s + 792*d) / (10*s), clamped to 20..100
   localparam int NUM_S_COEF  = 208;
   localparam int NUM_D_COEF  = 792;
   localparam int CLAMP_COEF  = 200;
   localparam int DEN_COEF    = 10;
   localparam int SPAN_W      = MV_W + 2;
   localparam int NUM_W       = 28;
   localparam int DEN_W       = 20;
   localparam int QUOT_BITS   = 7;
   localparam int REM_W       = DEN_W + QUOT_BITS - 1;

   localparam logic [OXY_W-1:0] OXY_MIN    = 7'd20;
   localparam logic [OXY_W-1:0] OXY_MAX    = 7'd100;
   localparam logic [EFF_W-1:0] EFF_MAX    = 8'd255;
   localparam logic [EFF_W-1:0] OPER_LIMIT = 8'd75;

   localparam int MUL_STEPS = 16;
   localparam int CNT_W     = 4;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_FILT = 7'b0000010,
      S_PREP = 7'b0000100,
      S_CALC = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_EFF  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

endpackage

### hw/rtl/oxy_if.sv
// Request, response and register-write channel interfaces.
// Depends on oxy_pkg for field widths.
interface oxy_req_if import oxy_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [MV_W-1:0]  sample_mv;
   logic             adc_ok;

   modport source (output valid, cmd, sample_mv, adc_ok, input ready);
   modport sink   (input valid, cmd, sample_mv, adc_ok, output ready);
endinterface

interface oxy_rsp_if import oxy_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OXY_W-1:0] oxygen_percent;
   logic [MV_W-1:0]  filtered_mv;
   logic [EFF_W-1:0] efficiency;
   logic             operational;
   logic             ready_res;
   logic             adc_fail;
   logic             span_fault;

   modport source (output valid, oxygen_percent, filtered_mv, efficiency, operational,
                   ready_res, adc_fail, span_fault, input ready);
   modport sink   (input valid, oxygen_percent, filtered_mv, efficiency, operational,
                   ready_res, adc_fail, span_fault, output ready);
endinterface

interface oxy_csr_if import oxy_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CSR_A_W-1:0] addr;
   logic [CSR_D_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

### hw/rtl/oxygen_sensor_ewma_calibrated_map.sv
// Oxygen sensor top level: bit-serial exponential filter, two-point span map
// and efficiency check. Depends on oxy_pkg and the interfaces in oxy_if.sv.
//
// One request is worked at a time. The filter is a bit-serial multiply-accumulate
// over the 16 sample bits, the span map is a restoring divider producing one
// quotient bit per cycle, and a capture adds a bit-serial multiply for the
// efficiency. A new request is taken in the cycle after the previous response is
// loaded into the output register, even while that response still waits for
// rsp_bus.ready. Register writes are accepted every cycle and must only occur
// while idle.
module oxygen_sensor_ewma_calibrated_map
   import oxy_pkg::*;
#(
   parameter int WEIGHT_FRAC_BITS = WFB_DEFAULT,
   parameter int SAMPLE_BITS      = SB_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   oxy_req_if.sink   req_bus,
   oxy_rsp_if.source rsp_bus,
   oxy_csr_if.sink   csr_bus
);

   localparam int AW = WEIGHT_FRAC_BITS + 1;
   localparam int CW = (AW > WEIGHT_W) ? AW : WEIGHT_W;
   localparam logic [CW-1:0]   FULL_C = CW'(1) << WEIGHT_FRAC_BITS;
   localparam logic [AW-1:0]   FULL_A = AW'(1) << WEIGHT_FRAC_BITS;
   localparam logic [MV_W-1:0] SMASK  = MV_W'((32'd1 << SAMPLE_BITS) - 32'd1);

   state_type state_ff;

   logic [WEIGHT_W-1:0] weight_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [MV_W-1:0]     smooth_ff, hi_off_ff, lo_off_ff;
   logic [EFF_W-1:0]    eff_ff;
   logic                oper_ff, rdy_ff;

   logic [CNT_W-1:0]    cnt_ff;
   logic                cap_ff, cap_hi_ff, fail_ff;
   logic [AW-1:0]       a_ff, fa_ff, acc_ff;
   logic [MV_W-1:0]     mp_ff, ms_ff, lo_ff, filt_ff;

   logic signed [SPAN_W-1:0] s_ff, d_ff;
   logic                     zero_ff, lowc_ff, highc_ff;
   logic [REM_W-1:0]         rem_ff, div_ff;
   logic [QUOT_BITS-1:0]     q_ff;
   logic [OXY_W-1:0]         oxy_ff;

   logic [MV_W-1:0]  em_ff, eacc_ff;
   logic             epos_ff;

   logic             rsp_valid_ff;
   logic [OXY_W-1:0] rsp_oxy_ff;
   logic [MV_W-1:0]  rsp_filt_ff;
   logic [EFF_W-1:0] rsp_eff_ff;
   logic             rsp_oper_ff, rsp_rdy_ff, rsp_fail_ff, rsp_fault_ff;

   // combinational helpers
   logic [CW-1:0]    w_ext;
   logic [AW-1:0]    a_in;
   logic [AW:0]      fsum;
   logic [AW-1:0]    acc_in;
   logic [MV_W-1:0]  lo_in;
   logic [AW+MV_W-1:0] filt_full;
   logic signed [SPAN_W-1:0] s_raw, d_raw;
   logic signed [NUM_W-1:0]  num_c, clamp_c;
   logic [DEN_W-1:0]         den_c;
   logic                     ge_c;
   logic [QUOT_BITS-1:0]     q_in;
   logic [OXY_W-1:0]         oxy_in;
   logic [MV_W:0]            es_c, esum;
   logic [MV_W-1:0]          eacc_in;
   logic [MV_W:0]            eraw;
   logic [EFF_W-1:0]         eff_in;
   logic                     req_fire, rsp_load, last_mul, last_div;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_load      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_bus.ready);
   assign last_mul      = (cnt_ff == CNT_W'(MUL_STEPS - 1));
   assign last_div      = (cnt_ff == CNT_W'(QUOT_BITS - 1));

   always_comb begin
      w_ext = CW'(weight_ff);
      if (weight_ff == '0) begin
         a_in = AW'(1);
      end else if (w_ext > FULL_C) begin
         a_in = FULL_A;
      end else begin
         a_in = AW'(w_ext);
      end
   end

   // filter step: acc + prev_bit*(F-a) + sample_bit*a, one bit shifted out
   assign fsum      = {1'b0, acc_ff} + (mp_ff[0] ? {1'b0, fa_ff} : '0)
                      + (ms_ff[0] ? {1'b0, a_ff} : '0);
   assign acc_in    = fsum[AW:1];
   assign lo_in     = {fsum[0], lo_ff[MV_W-1:1]};
   assign filt_full = {acc_in, lo_in};

   assign s_raw = $signed({2'b00, hi_off_ff}) - $signed({2'b00, lo_off_ff});
   assign d_raw = $signed({2'b00, filt_ff}) - $signed({2'b00, lo_off_ff});

   assign num_c   = NUM_W'(s_ff) * NUM_W'(NUM_S_COEF) + NUM_W'(d_ff) * NUM_W'(NUM_D_COEF);
   assign clamp_c = NUM_W'(s_ff) * NUM_W'(CLAMP_COEF);
   assign den_c   = DEN_W'(s_ff[MV_W:0]) * DEN_W'(DEN_COEF);

   assign ge_c = (rem_ff >= div_ff);
   assign q_in = {q_ff[QUOT_BITS-2:0], ge_c};

   always_comb begin
      if (zero_ff || lowc_ff) begin
         oxy_in = OXY_MIN;
      end else if (highc_ff) begin
         oxy_in = OXY_MAX;
      end else begin
         oxy_in = q_in;
      end
   end

   assign es_c    = {1'b0, hi_off_ff} - {1'b0, lo_off_ff};
   assign esum    = {1'b0, eacc_ff} + (em_ff[0] ? {1'b0, gain_ff} : '0);
   assign eacc_in = esum[MV_W:1];
   assign eraw    = {1'b0, eacc_in} + (MV_W+1)'(esum[0]);

   always_comb begin
      if (!epos_ff) begin
         eff_in = '0;
      end else if (eraw > (MV_W+1)'(EFF_MAX)) begin
         eff_in = EFF_MAX;
      end else begin
         eff_in = eraw[EFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_WEIGHT: weight_ff <= csr_bus.data[WEIGHT_W-1:0];
            CSR_GAIN:   gain_ff   <= csr_bus.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         smooth_ff <= '0;
         hi_off_ff <= HI_OFF_RESET;
         lo_off_ff <= LO_OFF_RESET;
         eff_ff    <= '0;
         oper_ff   <= 1'b1;
         rdy_ff    <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  a_ff      <= a_in;
                  fa_ff     <= FULL_A - a_in;
                  acc_ff    <= '0;
                  mp_ff     <= smooth_ff;
                  ms_ff     <= req_bus.adc_ok ? (req_bus.sample_mv & SMASK) : '0;
                  cap_ff    <= (req_bus.cmd == CMD_CAP_LO) || (req_bus.cmd == CMD_CAP_HI);
                  cap_hi_ff <= (req_bus.cmd == CMD_CAP_HI);
                  fail_ff   <= !req_bus.adc_ok;
                  cnt_ff    <= '0;
                  state_ff  <= S_FILT;
               end
            end
            S_FILT: begin
               acc_ff <= acc_in;
               lo_ff  <= lo_in;
               mp_ff  <= mp_ff >> 1;
               ms_ff  <= ms_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (last_mul) begin
                  filt_ff  <= filt_full[WEIGHT_FRAC_BITS+MV_W-1:WEIGHT_FRAC_BITS];
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               // map uses the offsets from before any capture
               zero_ff  <= (s_raw == '0);
               s_ff     <= s_raw[SPAN_W-1] ? -s_raw : s_raw;
               d_ff     <= s_raw[SPAN_W-1] ? -d_raw : d_raw;
               smooth_ff <= cap_ff ? '0 : filt_ff;
               if (cap_ff) begin
                  rdy_ff <= 1'b1;
                  if (cap_hi_ff) begin
                     hi_off_ff <= filt_ff;
                  end else begin
                     lo_off_ff <= filt_ff;
                  end
               end
               state_ff <= S_CALC;
            end
            S_CALC: begin
               lowc_ff  <= (num_c < clamp_c);
               highc_ff <= (d_ff >= s_ff);
               rem_ff   <= num_c[REM_W-1:0];
               div_ff   <= {den_c, (QUOT_BITS-1)'(0)};
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= ge_c ? (rem_ff - div_ff) : rem_ff;
               div_ff <= div_ff >> 1;
               q_ff   <= q_in;
               if (last_div) begin
                  oxy_ff  <= oxy_in;
                  epos_ff <= !es_c[MV_W] && (es_c != '0);
                  em_ff   <= es_c[MV_W-1:0];
                  eacc_ff <= '0;
                  cnt_ff  <= '0;
                  state_ff <= cap_ff ? S_EFF : S_FIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_EFF: begin
               eacc_ff <= eacc_in;
               em_ff   <= em_ff >> 1;
               cnt_ff  <= cnt_ff + 1'b1;
               if (last_mul) begin
                  eff_ff <= eff_in;
                  if (eff_in <= OPER_LIMIT) begin
                     oper_ff <= 1'b0;
                  end
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_oxy_ff   <= oxy_ff;
         rsp_filt_ff  <= filt_ff;
         rsp_eff_ff   <= eff_ff;
         rsp_oper_ff  <= oper_ff;
         rsp_rdy_ff   <= rdy_ff;
         rsp_fail_ff  <= fail_ff;
         rsp_fault_ff <= zero_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.oxygen_percent = rsp_oxy_ff;
   assign rsp_bus.filtered_mv    = rsp_filt_ff;
   assign rsp_bus.efficiency     = rsp_eff_ff;
   assign rsp_bus.operational    = rsp_oper_ff;
   assign rsp_bus.ready_res      = rsp_rdy_ff;
   assign rsp_bus.adc_fail       = rsp_fail_ff;
   assign rsp_bus.span_fault     = rsp_fault_ff;

`ifndef SYNTH
   a_oper_sticky: assert property (@(posedge clock) disable iff (reset)
      !oper_ff |=> !oper_ff)
      else $error("operational flag came back after clearing");

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      rdy_ff |=> rdy_ff)
      else $error("ready flag dropped");

   a_fault_oxy: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.span_fault |-> rsp_bus.oxygen_percent == OXY_MIN)
      else $error("span fault without minimum oxygen");

   a_oxy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.oxygen_percent >= OXY_MIN
                        && rsp_bus.oxygen_percent <= OXY_MAX)
      else $error("oxygen out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_FILT && cnt_ff == '0)
      else $error("accepted request did not start the filter");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for oxygen_sensor_ewma_calibrated_map: a directed table,
// then randomized phases under several register settings and idle patterns.
// Depends on oxy_pkg and the channel interfaces in oxy_if.sv.
module tb_top;
   import oxy_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam longint unsigned  W_FULL = 64'd1 << WFB_DEFAULT;
   localparam int N_DIRECTED   = 20;
   localparam int N_PHASES     = 6;
   localparam int ITEMS_PHASE  = 85;
   localparam int DRAIN_CYCLES = 50;
   localparam int QUIET_LIMIT  = 4000;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [MV_W-1:0]  sample_mv;
      logic             adc_ok;
   } sample_req_type;

   typedef struct packed {
      logic [OXY_W-1:0] oxygen_percent;
      logic [MV_W-1:0]  filtered_mv;
      logic [EFF_W-1:0] efficiency;
      logic             operational;
      logic             ready_res;
      logic             adc_fail;
      logic             span_fault;
   } reading_type;

   typedef struct packed {
      logic           typed;
      sample_req_type rq;
      reading_type    want;
   } dir_row_type;

   localparam reading_type NO_READING = '0;

   // typed rows: reset state, full-scale high capture, zero span
   dir_row_type dir_tab [N_DIRECTED] = '{
      '{1'b1, '{CMD_SAMPLE, 16'h0000, 1'b1}, '{7'd20,  16'd0,     8'd0,   1'b1, 1'b0, 1'b0, 1'b0}},
      '{1'b1, '{CMD_SAMPLE, 16'hFFFF, 1'b0}, '{7'd20,  16'd0,     8'd0,   1'b1, 1'b0, 1'b1, 1'b0}},
      '{1'b1, '{CMD_CAP_HI, 16'hFFFF, 1'b1}, '{7'd100, 16'd19647, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{1'b1, '{CMD_SAMPLE, 16'hFFFF, 1'b1}, '{7'd100, 16'd19647, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '{CMD_CAP_LO, 16'h0000, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SAMPLE, 16'h0000, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SAMPLE, 16'h8000, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SAMPLE, 16'h5555, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SAMPLE, 16'hAAAA, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SPARE,  16'h4000, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SPARE,  16'hFFFF, 1'b0}, NO_READING},
      '{1'b0, '{CMD_CAP_LO, 16'h4000, 1'b1}, NO_READING},
      '{1'b0, '{CMD_CAP_LO, 16'h4000, 1'b1}, NO_READING},
      '{1'b1, '{CMD_CAP_HI, 16'h4000, 1'b1}, '{7'd20,  16'd4912,  8'd0,   1'b0, 1'b1, 1'b0, 1'b0}},
      '{1'b1, '{CMD_SAMPLE, 16'h4000, 1'b1}, '{7'd20,  16'd4912,  8'd0,   1'b0, 1'b1, 1'b0, 1'b1}},
      '{1'b0, '{CMD_SAMPLE, 16'hFFFF, 1'b0}, NO_READING},
      '{1'b0, '{CMD_CAP_LO, 16'hFFFF, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SAMPLE, 16'h0000, 1'b1}, NO_READING},
      '{1'b0, '{CMD_SAMPLE, 16'hFFFF, 1'b1}, NO_READING},
      '{1'b0, '{CMD_CAP_HI, 16'h0000, 1'b0}, NO_READING}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   oxy_req_if req_bus ();
   oxy_rsp_if rsp_bus ();
   oxy_csr_if csr_bus ();

   oxygen_sensor_ewma_calibrated_map dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor copy of block state and registers
   logic [MV_W-1:0]     smoothed_mv;
   logic [MV_W-1:0]     hi_off_mv;
   logic [MV_W-1:0]     lo_off_mv;
   logic [EFF_W-1:0]    eff_val;
   logic                oper_flag;
   logic                rdy_flag;
   logic [WEIGHT_W-1:0] weight_reg;
   logic [GAIN_W-1:0]   gain_reg;

   reading_type pending_readings [$];
   int       mismatches   = 0;
   int       quiet_cycles = 0;
   int       tx_idle_pct  = 0;
   int       rx_stall_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic reading_type predict_reading(input sample_req_type rq);
      reading_type     rs;
      longint unsigned a;
      longint unsigned smp;
      longint          d;
      longint          s;
      longint          num;
      longint          den;
      longint          e;
      logic [MV_W-1:0] filt;
      a = weight_reg;
      if (a == 0) a = 1;
      if (a > W_FULL) a = W_FULL;
      smp  = rq.adc_ok ? longint'(rq.sample_mv) : 0;
      filt = MV_W'(((W_FULL - a) * smoothed_mv + a * smp) >> WFB_DEFAULT);
      smoothed_mv = filt;

      d = longint'(filt) - longint'(lo_off_mv);
      s = longint'(hi_off_mv) - longint'(lo_off_mv);
      rs.span_fault = (s == 0);
      if (s == 0) begin
         rs.oxygen_percent = 7'd20;
      end else begin
         if (s < 0) begin
            s = -s;
            d = -d;
         end
         num = 208 * s + 792 * d;
         den = 10 * s;
         if (num < 20 * den) rs.oxygen_percent = 7'd20;
         else if (num >= 100 * den) rs.oxygen_percent = 7'd100;
         else rs.oxygen_percent = OXY_W'(num / den);
      end

      if (rq.cmd == CMD_CAP_LO || rq.cmd == CMD_CAP_HI) begin
         if (rq.cmd == CMD_CAP_HI) hi_off_mv = filt;
         else lo_off_mv = filt;
         smoothed_mv = '0;
         rdy_flag    = 1'b1;
         s = longint'(hi_off_mv) - longint'(lo_off_mv);
         e = 0;
         if (s > 0) begin
            e = (longint'(gain_reg) * s + 32768) >>> 16;
            if (e > 255) e = 255;
         end
         eff_val = EFF_W'(e);
         if (eff_val <= 8'd75) oper_flag = 1'b0;
      end

      rs.filtered_mv = filt;
      rs.efficiency  = eff_val;
      rs.operational = oper_flag;
      rs.ready_res   = rdy_flag;
      rs.adc_fail    = !rq.adc_ok;
      return rs;
   endfunction

   task automatic send_request(input sample_req_type rq, input logic typed,
                               input reading_type want);
      reading_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= rq.cmd;
      req_bus.sample_mv <= rq.sample_mv;
      req_bus.adc_ok    <= rq.adc_ok;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_reading(rq);
      pending_readings.push_back(typed ? want : predicted);
   endtask

   task automatic write_reg(input logic [CSR_A_W-1:0] idx, input logic [CSR_D_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_WEIGHT) weight_reg = val[WEIGHT_W-1:0];
      else if (idx == CSR_GAIN) gain_reg = val;
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_readings.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            check_field("oxygen_percent", want.oxygen_percent, rsp_bus.oxygen_percent);
            check_field("filtered_mv", want.filtered_mv, rsp_bus.filtered_mv);
            check_field("efficiency", want.efficiency, rsp_bus.efficiency);
            check_field("operational", want.operational, rsp_bus.operational);
            check_field("ready_res", want.ready_res, rsp_bus.ready_res);
            check_field("adc_fail", want.adc_fail, rsp_bus.adc_fail);
            check_field("span_fault", want.span_fault, rsp_bus.span_fault);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [CSR_D_W-1:0] weight_plan [N_PHASES];
      logic [CSR_D_W-1:0] gain_plan [N_PHASES];
      sample_req_type     rq;
      logic [MV_W-1:0]    level;
      int                 pick;

      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_SAMPLE;
      req_bus.sample_mv <= '0;
      req_bus.adc_ok    <= 1'b1;
      csr_bus.valid     <= 1'b0;
      csr_bus.addr      <= CSR_WEIGHT;
      csr_bus.data      <= '0;

      smoothed_mv = '0;
      hi_off_mv   = HI_OFF_RESET;
      lo_off_mv   = LO_OFF_RESET;
      eff_val     = '0;
      oper_flag   = 1'b1;
      rdy_flag    = 1'b0;
      weight_reg  = WEIGHT_RESET;
      gain_reg    = GAIN_RESET;

      // weight: full, minimum, zero, all ones, random, default
      weight_plan = '{16'd1024, 16'd1, 16'd0, 16'hFFFF,
                      CSR_D_W'($urandom_range(2047)), 16'd307};
      gain_plan   = '{16'hFFFF, 16'd0, 16'd8624, CSR_D_W'($urandom),
                      CSR_D_W'($urandom), CSR_D_W'($urandom)};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         send_request(dir_tab[r].rq, dir_tab[r].typed, dir_tab[r].want);
      end
      req_bus.valid <= 1'b0;

      level = MV_W'($urandom);
      for (int p = 0; p < N_PHASES; p++) begin
         while (pending_readings.size() != 0) @(posedge clock);
         tx_idle_pct  = 0;
         rx_stall_pct = 0;
         write_reg(CSR_WEIGHT, weight_plan[p]);
         write_reg(CSR_GAIN, gain_plan[p]);
         csr_bus.valid <= 1'b0;
         case ((p + 1) % 4)
            1: begin
               tx_idle_pct = 72;
            end
            2: begin
               rx_stall_pct = 72;
            end
            3: begin
               tx_idle_pct  = 26;
               rx_stall_pct = 26;
            end
            default: begin
            end
         endcase
         for (int i = 0; i < ITEMS_PHASE; i++) begin
            pick = $urandom_range(99);
            if (pick < 66) rq.cmd = CMD_SAMPLE;
            else if (pick < 78) rq.cmd = CMD_CAP_LO;
            else if (pick < 90) rq.cmd = CMD_CAP_HI;
            else rq.cmd = CMD_SPARE;
            // settle near a level so captures land on steady readings
            pick = $urandom_range(99);
            if (pick < 8) rq.sample_mv = '0;
            else if (pick < 16) rq.sample_mv = '1;
            else if (pick < 60) rq.sample_mv = level + MV_W'($urandom_range(255));
            else rq.sample_mv = MV_W'($urandom);
            rq.adc_ok = ($urandom_range(9) != 0);
            send_request(rq, 1'b0, NO_READING);
            if (rq.cmd == CMD_CAP_LO || rq.cmd == CMD_CAP_HI) level = MV_W'($urandom);
         end
         req_bus.valid <= 1'b0;
      end

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
